// File: rtl/mpaw_pkg.sv
// ----------------------------------------------------------------------------
// mpaw_pkg: shared types and constants for the max pooling window block
// Holds the line store geometry and the register codes.
// ----------------------------------------------------------------------------
package mpaw_pkg;

  localparam int ValueW = 16;
  localparam int IndexW = 4;

  // Line store geometry: rows kept, widest row and most channels per position.
  localparam int MAX_WINDOW   = 4;
  localparam int MAX_COLS     = 256;
  localparam int MAX_CHANNELS = 16;
  localparam int RowW  = $clog2(MAX_WINDOW);
  localparam int ColW  = $clog2(MAX_COLS);
  localparam int ChW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AddrW = RowW + ColW + ChW;
  localparam int Depth = MAX_WINDOW * MAX_COLS * MAX_CHANNELS;

  typedef enum logic [2:0] {
    REG_WINDOW_SIZE = 3'd0,
    REG_STRIDE      = 3'd1,
    REG_IN_ROWS     = 3'd2,
    REG_IN_COLS     = 3'd3,
    REG_CHANNELS    = 3'd4
  } reg_index_t;

endpackage

// File: rtl/mpaw_front.sv
// ----------------------------------------------------------------------------
// mpaw_front: position tracking and window classification
// Counts row, column and channel of each word, writes it into the line store
// and, when it completes a pooled window, issues a job for the back end.
// ----------------------------------------------------------------------------
module mpaw_front
  import mpaw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [2:0]        ws,
  input  logic [2:0]        st,
  input  logic [11:0]       nr,
  input  logic [12:0]       nc,
  input  logic [8:0]        nch,
  input  logic              in_fire,
  output logic              job_valid,
  output logic [11:0]       job_br,
  output logic [12:0]       job_bc,
  output logic [8:0]        job_ch,
  output logic              job_last,
  output logic              wr_en,
  output logic [AddrW-1:0]  wr_addr,
  output logic              lim_busy
);

  logic [11:0] row;
  logic [12:0] col;
  logic [8:0]  ch;
  // row and column phases modulo stride and the last window origins
  logic [2:0]  rph, cph;
  logic [11:0] last_r;
  logic [12:0] last_c;
  logic [11:0] br;
  logic [12:0] bc;
  logic        hit;
  logic [11:0] lr_acc;
  logic [12:0] lc_acc;
  logic        r_more, c_more;

  assign br = row + 12'd1 - 12'(ws);
  assign bc = col + 13'd1 - 13'(ws);
  assign wr_en = in_fire;
  assign wr_addr = {row[RowW-1:0], col[ColW-1:0], ch[ChW-1:0]};

  // Origin phase: base row br is aligned when br mod st == 0. Each phase
  // counter is zero at the first window origin of its axis and steps with
  // every later row or column, wrapping at the stride.
  assign hit = (12'(nr) >= 12'(ws)) && (nc >= 13'(ws)) &&
               (row + 12'd1 >= 12'(ws)) && (col + 13'd1 >= 13'(ws)) &&
               (rph == 3'd0) && (cph == 3'd0) && (br <= last_r) && (bc <= last_c);

  // Last origins computed directly after clear would need a divider; the
  // map is at most 4095 rows, so add stride in a small loop instead.
  assign r_more = (13'(lr_acc) + 13'(st) + 13'(ws)) <= 13'(nr);
  assign c_more = (lc_acc + 13'(st) + 13'(ws)) <= nc;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      lim_busy <= 1'b1;
      lr_acc   <= 12'd0;
      lc_acc   <= 13'd0;
      last_r   <= 12'd0;
      last_c   <= 13'd0;
    end else if (lim_busy) begin
      if (r_more) lr_acc <= lr_acc + 12'(st);
      if (c_more) lc_acc <= lc_acc + 13'(st);
      if (!r_more && !c_more) begin
        lim_busy <= 1'b0;
        last_r   <= lr_acc;
        last_c   <= lc_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row <= '0; col <= '0; ch <= '0;
      rph <= 3'd0; cph <= 3'd0;
      job_valid <= 1'b0;
    end else begin
      job_valid <= in_fire && hit;
      if (in_fire) begin
        job_br   <= br;
        job_bc   <= bc;
        job_ch   <= ch;
        job_last <= (br == last_r) && (bc == last_c) && (ch + 9'd1 == nch);
        if (ch + 9'd1 < nch) begin
          ch <= ch + 9'd1;
        end else begin
          ch <= '0;
          if (col + 13'd1 < nc) begin
            col <= col + 13'd1;
            if (col + 13'd1 >= 13'(ws)) cph <= (cph == st - 3'd1) ? 3'd0 : cph + 3'd1;
          end else begin
            col <= '0;
            cph <= 3'd0;
            if (row + 12'd1 < nr) begin
              row <= row + 12'd1;
              if (row + 12'd1 >= 12'(ws)) rph <= (rph == st - 3'd1) ? 3'd0 : rph + 3'd1;
            end else begin
              row <= '0;
              rph <= 3'd0;
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/mpaw_back.sv
// ----------------------------------------------------------------------------
// mpaw_back: window scan
// Reads one window entry per cycle from the line store and keeps the first
// strict maximum, then holds the result in an output register.
// ----------------------------------------------------------------------------
module mpaw_back
  import mpaw_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [2:0]               ws,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  logic [11:0]              q_br,
  input  logic [12:0]              q_bc,
  input  logic [8:0]               q_ch,
  input  logic                     q_last,
  output logic [AddrW-1:0]         rd_addr,
  input  logic signed [ValueW-1:0] rd_data,
  output logic                     m_valid,
  input  logic                     m_ready,
  output logic signed [ValueW-1:0] m_value,
  output logic [IndexW-1:0]        m_index,
  output logic                     m_last
);

  typedef enum logic [1:0] {IDLE, SCAN, DONE} state_t;
  state_t state;
  logic [2:0] ro, co;
  logic [IndexW-1:0] idx, lag_idx;
  logic lag_v;
  logic signed [ValueW-1:0] best;
  logic [IndexW-1:0] best_i;
  logic scan_last;
  logic [11:0] r;
  logic [12:0] c;
  logic hand_off;

  assign r = q_br + 12'(ro);
  assign c = q_bc + 13'(co);
  assign rd_addr = {r[RowW-1:0], c[ColW-1:0], q_ch[ChW-1:0]};
  assign q_pop = (state == SCAN) && (ro == ws - 3'd1) && (co == ws - 3'd1);
  // The finished window moves to the output register once the previous
  // result has gone or is taken at this edge.
  assign hand_off = (state == DONE) && !lag_v && (!m_valid || m_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE; lag_v <= 1'b0; m_valid <= 1'b0;
    end else begin
      if (hand_off) begin
        m_valid <= 1'b1; m_value <= best; m_index <= best_i; m_last <= scan_last;
      end else if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      lag_v <= (state == SCAN);
      lag_idx <= idx;
      if (lag_v) begin
        if (lag_idx == '0 || rd_data > best) begin
          best <= rd_data; best_i <= lag_idx;
        end
      end
      unique case (state)
        IDLE: if (q_valid) begin
          state <= SCAN; ro <= '0; co <= '0; idx <= '0; scan_last <= q_last;
        end
        SCAN: begin
          idx <= idx + 1'b1;
          if (ro == ws - 3'd1) begin
            ro <= '0; co <= co + 3'd1;
          end else ro <= ro + 3'd1;
          if (q_pop) state <= DONE;
        end
        DONE: if (hand_off) begin
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_scan: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop without job");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_valid && !m_ready |=> m_valid) else $error("result dropped");
  a_idx_rng: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> 6'(m_index) < 6'(ws) * 6'(ws)) else $error("index out of window");
`endif

endmodule

// File: rtl/max_pool_argmax_window.sv
// ----------------------------------------------------------------------------
// max_pool_argmax_window: streaming 2-D max pooling with argmax
// Channel  | Dir | Payload
// s_axis   | in  | tdata[15:0] sample_value
// m_axis   | out | tdata[15:0] pooled_value, tdata[19:16] argmax_index; tlast
// apb      | in  | registers window_size, stride, in_rows, in_cols, channels
// A word that completes no window does not hold back the next word. A word
// that completes a window holds off the next word until its job has passed
// the job register, the queue and pickup and its ws*ws line store reads are
// done; its result then goes to the output register. Input is held while
// a job waits or is scanned, so no later word overwrites a window row
// before it is read. An untaken result stalls the back end only once the
// next window is scanned. After reset or a register write, a stride-step
// loop finds the last window origins; no words are accepted meanwhile.
// Reset is synchronous and active high.
// ----------------------------------------------------------------------------
module max_pool_argmax_window
  import mpaw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // pooled_value, argmax_index, zero fill
  output logic        m_axis_tlast,   // last_of_map
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0] r_ws, r_st;
  logic [11:0] r_rows;
  logic [8:0] r_cols;
  logic [4:0] r_ch;
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_ws <= 3'd2; r_st <= 3'd2; r_rows <= 12'd32; r_cols <= 9'd32; r_ch <= 5'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_WINDOW_SIZE: r_ws   <= pwdata[2:0];
        REG_STRIDE:      r_st   <= pwdata[2:0];
        REG_IN_ROWS:     r_rows <= pwdata[11:0];
        REG_IN_COLS:     r_cols <= pwdata[8:0];
        REG_CHANNELS:    r_ch   <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_WINDOW_SIZE: prdata = {29'd0, r_ws};
      REG_STRIDE:      prdata = {29'd0, r_st};
      REG_IN_ROWS:     prdata = {20'd0, r_rows};
      REG_IN_COLS:     prdata = {23'd0, r_cols};
      REG_CHANNELS:    prdata = {27'd0, r_ch};
      default:         prdata = '0;
    endcase
  end

  // Effective values with out-of-range codes mapped as specified.
  logic [2:0] ews, est;
  logic [11:0] enr;
  logic [12:0] enc;
  logic [8:0] ench;
  logic clr;
  assign ews  = (r_ws < 3'd2) ? 3'd2 : (32'(r_ws) > MAX_WINDOW) ? 3'(MAX_WINDOW) : r_ws;
  assign est  = (r_st == 3'd0) ? 3'd1 : r_st;
  assign enr  = (r_rows == 12'd0) ? 12'd1 : r_rows;
  assign enc  = (r_cols == 9'd0) ? 13'd1 :
                (32'(r_cols) > MAX_COLS) ? 13'(MAX_COLS) : 13'(r_cols);
  assign ench = (r_ch == 5'd0) ? 9'd1 :
                (32'(r_ch) > MAX_CHANNELS) ? 9'(MAX_CHANNELS) : 9'(r_ch);
  assign clr  = cfg_wr && paddr[4:2] <= REG_CHANNELS;

  // Job queue between front and back end.
  localparam int QD = 4;
  logic [34:0] q_mem [QD];
  logic [2:0] q_cnt;
  logic [1:0] q_wp, q_rp;
  logic in_fire, lim_busy;
  logic job_v, job_last, wr_en, q_pop;
  logic [11:0] job_br;
  logic [12:0] job_bc;
  logic [8:0] job_ch;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic signed [15:0] store [Depth];
  logic signed [15:0] rd_data;
  logic signed [ValueW-1:0] res_value;
  logic [IndexW-1:0] res_index;

  // A word is taken only when no job is registered, queued or being scanned.
  assign s_axis_tready = (q_cnt == 3'd0) && !job_v && !lim_busy && !clr;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  mpaw_front u_front (
    .clk, .rst, .clear(clr), .ws(ews), .st(est), .nr(enr), .nc(enc), .nch(ench),
    .in_fire, .job_valid(job_v), .job_br, .job_bc, .job_ch, .job_last,
    .wr_en, .wr_addr, .lim_busy);

  always_ff @(posedge clk) begin
    if (wr_en) store[wr_addr] <= s_axis_tdata;
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      q_cnt <= '0; q_wp <= '0; q_rp <= '0;
    end else begin
      if (job_v) begin
        q_mem[q_wp] <= {job_last, job_ch, job_bc, job_br};
        q_wp <= q_wp + 2'd1;
      end
      if (q_pop) q_rp <= q_rp + 2'd1;
      q_cnt <= q_cnt + 3'(job_v) - 3'(q_pop);
    end
  end

  mpaw_back u_back (
    .clk, .rst, .ws(ews), .q_valid(q_cnt != 3'd0), .q_pop,
    .q_br(q_mem[q_rp][11:0]), .q_bc(q_mem[q_rp][24:12]),
    .q_ch(q_mem[q_rp][33:25]), .q_last(q_mem[q_rp][34]),
    .rd_addr, .rd_data, .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .m_value(res_value), .m_index(res_index),
    .m_last(m_axis_tlast));

  assign m_axis_tdata = {4'd0, res_index, res_value};

endmodule
